/* sv/dth_pkg.sv */
// ----------------------------------------------------------------------------
// dth_pkg - shared types and constants for the ordered dither block
// Word types, threshold matrices and the phase helper shared by all modules.
// ----------------------------------------------------------------------------
package dth_pkg;

   localparam int MAX_WIDTH_DEF = 4096;

   localparam int GRAY_W    = 8;
   localparam int LWIDTH_W  = 13;
   localparam int CSR_W     = 13;
   localparam int PHASE_W   = 4;
   localparam int PHASE_MOD = 12;
   localparam int PROD_W    = 10;

   localparam logic [LWIDTH_W-1:0] LINE_WIDTH_RST = 13'd640;

   // Register indexes on the CSR port
   typedef enum logic [0:0] {
      CSR_GRAY_PEAK  = 1'b0,
      CSR_LINE_WIDTH = 1'b1
   } csr_index_type;

   // floor(x/9) for 8-bit x as (x*57) >> 9
   localparam logic [13:0] RECIP9       = 14'd57;
   localparam int          RECIP9_SHIFT = 9;

   // Steps for a peak gray of 255
   localparam logic [5:0] STEP2_RST = 6'd63;
   localparam logic [4:0] STEP3_RST = 5'd28;
   localparam logic [3:0] STEP4_RST = 4'd15;

   localparam logic [1:0] THR2 [4]  = '{2'd0, 2'd2, 2'd3, 2'd1};
   localparam logic [3:0] THR3 [9]  = '{4'd2, 4'd6, 4'd4, 4'd5, 4'd0, 4'd1, 4'd8, 4'd3, 4'd7};
   localparam logic [3:0] THR4 [16] = '{4'd0, 4'd8, 4'd2, 4'd10, 4'd12, 4'd4, 4'd14, 4'd6,
                                        4'd3, 4'd11, 4'd1, 4'd9, 4'd15, 4'd7, 4'd13, 4'd5};

   // Top level index per matrix size (N*N - 1)
   localparam logic [3:0] TOP2 = 4'd3;
   localparam logic [3:0] TOP3 = 4'd8;
   localparam logic [3:0] TOP4 = 4'd15;

   typedef struct packed {
      logic [GRAY_W-1:0] gray;
      logic              frame_start;
   } req_type;

   typedef struct packed {
      logic bit_2x2;
      logic bit_3x3;
      logic bit_4x4;
   } rsp_type;

   typedef struct packed {
      logic [5:0] step2;
      logic [4:0] step3;
      logic [3:0] step4;
   } step_type;

   typedef struct packed {
      logic [PHASE_W-1:0] row;
      logic [PHASE_W-1:0] col;
   } phase_type;

   // phase (0..11) mod 3
   function automatic logic [1:0] mod3(input logic [PHASE_W-1:0] ph);
      logic [1:0] r;
      unique case (ph)
         4'd0, 4'd3, 4'd6, 4'd9:  r = 2'd0;
         4'd1, 4'd4, 4'd7, 4'd10: r = 2'd1;
         4'd2, 4'd5, 4'd8, 4'd11: r = 2'd2;
         default:                 r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

/* sv/dth_cfg.sv */
// ----------------------------------------------------------------------------
// dth_cfg - configuration registers
// Holds line width and the quantization steps derived from the peak gray.
// ----------------------------------------------------------------------------
module dth_cfg (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [0:0]                       csr_index,
   input  logic [dth_pkg::CSR_W-1:0]        csr_data,
   output dth_pkg::step_type                steps,
   output logic [dth_pkg::LWIDTH_W-1:0]     line_width
);
   import dth_pkg::*;

   step_type             steps_ff, steps_in;
   logic [LWIDTH_W-1:0]  lwidth_ff, lwidth_in;
   logic [GRAY_W-1:0]    mv;
   logic [13:0]          prod9;

   always_comb begin
      mv        = csr_data[GRAY_W-1:0];
      prod9     = 14'(mv) * RECIP9;
      steps_in  = steps_ff;
      lwidth_in = lwidth_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRAY_PEAK: begin
               steps_in.step2 = mv[7:2];
               steps_in.step3 = prod9[RECIP9_SHIFT +: 5];
               steps_in.step4 = mv[7:4];
            end
            CSR_LINE_WIDTH: begin
               lwidth_in = csr_data[LWIDTH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff  <= '{step2: STEP2_RST, step3: STEP3_RST, step4: STEP4_RST};
         lwidth_ff <= LINE_WIDTH_RST;
      end else begin
         steps_ff  <= steps_in;
         lwidth_ff <= lwidth_in;
      end
   end

   assign steps      = steps_ff;
   assign line_width = lwidth_ff;

endmodule

/* sv/dth_pos.sv */
// ----------------------------------------------------------------------------
// dth_pos - raster position tracker
// Column count plus row/column phases mod 12; advances once per accepted word.
// ----------------------------------------------------------------------------
module dth_pos #(
   parameter int MAX_WIDTH = dth_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          frame_start,
   input  logic [dth_pkg::LWIDTH_W-1:0]  line_width,
   output dth_pkg::phase_type            phase
);
   import dth_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int EW = (CW + 1 > LWIDTH_W) ? CW + 1 : LWIDTH_W;
   localparam logic [EW-1:0] MAXW = EW'(MAX_WIDTH);

   logic [CW-1:0]      count_ff, count_in;
   logic [PHASE_W-1:0] row_ff, row_in, col_ff, col_in;
   logic [CW-1:0]      count_cur;
   logic [EW-1:0]      lw_ext, eff_width, count_next;
   logic               row_end;

   always_comb begin
      // frame start restarts position before this word is used
      count_cur = frame_start ? '0 : count_ff;
      phase.row = frame_start ? '0 : row_ff;
      phase.col = frame_start ? '0 : col_ff;

      lw_ext = EW'(line_width);
      if (lw_ext == '0)
         eff_width = EW'(1);
      else if (lw_ext > MAXW)
         eff_width = MAXW;
      else
         eff_width = lw_ext;

      count_next = EW'(count_cur) + EW'(1);
      row_end    = (count_next >= eff_width);

      count_in = count_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      if (accept) begin
         if (row_end) begin
            count_in = '0;
            col_in   = '0;
            row_in   = (phase.row == PHASE_W'(PHASE_MOD - 1)) ? '0
                                                              : phase.row + PHASE_W'(1);
         end else begin
            count_in = count_next[CW-1:0];
            col_in   = (phase.col == PHASE_W'(PHASE_MOD - 1)) ? '0
                                                              : phase.col + PHASE_W'(1);
            row_in   = phase.row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         count_ff <= count_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      EW'(count_ff) < MAXW)
      else $error("column count beyond max width");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      row_ff < PHASE_W'(PHASE_MOD) && col_ff < PHASE_W'(PHASE_MOD))
      else $error("phase out of range");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      accept && frame_start |=> col_ff <= PHASE_W'(1) && row_ff <= PHASE_W'(1))
      else $error("frame start did not restart position");

endmodule

/* sv/dth_core.sv */
// ----------------------------------------------------------------------------
// dth_core - two-register dither datapath
// Input register holds gray and matrix thresholds; result register holds bits.
// ----------------------------------------------------------------------------
module dth_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dth_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output dth_pkg::rsp_type    rsp_data,
   input  dth_pkg::phase_type  phase,
   input  dth_pkg::step_type   steps,
   output logic                accept
);
   import dth_pkg::*;

   // bit = level > t, i.e. t below top level and gray > (t+1)*step
   function automatic logic dbit(input logic [GRAY_W-1:0] g, input logic [3:0] t,
                                 input logic [3:0] top, input logic [5:0] step);
      logic [PROD_W-1:0] thr;
      thr = PROD_W'((PROD_W'(t) + PROD_W'(1)) * PROD_W'(step));
      return (t < top) && (PROD_W'(g) > thr);
   endfunction

   logic               s1_valid_ff, s1_valid_in;
   logic [GRAY_W-1:0]  gray_ff, gray_in;
   logic [1:0]         t2_ff, t2_in;
   logic [3:0]         t3_ff, t3_in, t4_ff, t4_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               out_free, s1_adv;
   logic [1:0]         r3, c3;
   logic [3:0]         idx3;

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      s1_adv    = s1_valid_ff && out_free;
      req_stall = s1_valid_ff && !out_free;
      accept    = req_valid && !req_stall;

      r3    = mod3(phase.row);
      c3    = mod3(phase.col);
      idx3  = 4'(r3) * 4'd3 + 4'(c3);

      s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      gray_in = gray_ff;
      t2_in   = t2_ff;
      t3_in   = t3_ff;
      t4_in   = t4_ff;
      if (accept) begin
         gray_in = req_data.gray;
         t2_in   = THR2[{phase.row[0], phase.col[0]}];
         t3_in   = THR3[idx3];
         t4_in   = THR4[{phase.row[1:0], phase.col[1:0]}];
      end

      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (s1_adv) begin
         rsp_in.bit_2x2 = dbit(gray_ff, 4'(t2_ff), TOP2, steps.step2);
         rsp_in.bit_3x3 = dbit(gray_ff, t3_ff, TOP3, 6'(steps.step3));
         rsp_in.bit_4x4 = dbit(gray_ff, t4_ff, TOP4, 6'(steps.step4));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      gray_ff <= gray_in;
      t2_ff   <= t2_in;
      t3_ff   <= t3_in;
      t4_ff   <= t4_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted word not in input register");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(gray_ff) && $stable(t4_ff))
      else $error("input register lost a word under stall");

   a_s1_moves: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("word advanced but no result valid");

endmodule

/* sv/ordered_dither_three_sizes_top.sv */
// ----------------------------------------------------------------------------
// ordered_dither_three_sizes_top - 2x2 / 3x3 / 4x4 ordered dither of gray pixels
// Path from req accept to rsp: input register, then result register.
// Throughput: one word per cycle; both registers advance together when rsp is free.
// req stalls only while both registers hold words and rsp is stalled.
// Reset (synchronous, high): position and valids clear, peak gray 255, width 640.
// ----------------------------------------------------------------------------
module ordered_dither_three_sizes_top #(
   parameter int MAX_WIDTH = dth_pkg::MAX_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // pixel words in
   input  logic                       req_valid,
   output logic                       req_stall,
   input  dth_pkg::req_type           req_data,
   // dithered bits out
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output dth_pkg::rsp_type           rsp_data,
   // register writes, always ready
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [0:0]                 csr_index,
   input  logic [dth_pkg::CSR_W-1:0]  csr_data
);
   import dth_pkg::*;

   step_type             steps;
   logic [LWIDTH_W-1:0]  line_width;
   phase_type            phase;
   logic                 accept;

   assign csr_ready = 1'b1;

   // Steps per matrix size are computed once per peak gray write.
   dth_cfg u_cfg (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .steps      (steps),
      .line_width (line_width)
   );

   // Row/column phase of the word at the req side, frame start applied.
   dth_pos #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_pos (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_start (req_data.frame_start),
      .line_width  (line_width),
      .phase       (phase)
   );

   // Threshold lookup into the input register, compares into the result register.
   dth_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .phase     (phase),
      .steps     (steps),
      .accept    (accept)
   );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - regression bench for the three-size ordered dither block
// Pixel words go in with random bursts and gaps, and the output side stalls on
// its own pattern, including one long hold that backs up the input. A
// scoreboard tracks position and registers and predicts the three bits for
// each accepted pixel. It then compares each output word with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import dth_pkg::*;

   // Bayer matrices, entry i in nibble i (row-major)
   localparam logic [15:0] DITHER2 = 16'h1320;
   localparam logic [35:0] DITHER3 = 36'h738105462;
   localparam logic [63:0] DITHER4 = 64'h5D7F91B36E4CA280;

   class dither_scoreboard;
      logic [7:0]  gray_peak;
      logic [12:0] line_width;
      logic [11:0] column_count;
      logic [3:0]  col_phase;
      logic [3:0]  row_phase;
      rsp_type     expected_bits[$];
      int          mismatches;
      int          pixels_seen;
      int          results_checked;

      function new();
         gray_peak       = 8'd255;
         line_width      = LINE_WIDTH_RST;
         column_count    = '0;
         col_phase       = '0;
         row_phase       = '0;
         mismatches      = 0;
         pixels_seen     = 0;
         results_checked = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [12:0] value);
         case (idx)
            CSR_GRAY_PEAK:  gray_peak  = value[7:0];
            CSR_LINE_WIDTH: line_width = value;
            default: ;
         endcase
      endfunction

      // level = count of k in 1..n*n-1 with gray above k steps; white if level > threshold
      function bit threshold_bit(int gray, int n, logic [63:0] matrix);
         int step;
         int lvl;
         int idx;
         step = int'(gray_peak) / (n * n);
         lvl  = 0;
         for (int k = 1; k < n * n; k++)
            if (gray > k * step) lvl++;
         idx = (int'(row_phase) % n) * n + (int'(col_phase) % n);
         return lvl > int'(matrix[idx*4 +: 4]);
      endfunction

      function void note_pixel(req_type px);
         rsp_type bits;
         int      width_eff;
         pixels_seen++;
         if (px.frame_start) begin
            column_count = '0;
            col_phase    = '0;
            row_phase    = '0;
         end
         bits.bit_2x2 = threshold_bit(px.gray, 2, 64'(DITHER2));
         bits.bit_3x3 = threshold_bit(px.gray, 3, 64'(DITHER3));
         bits.bit_4x4 = threshold_bit(px.gray, 4, DITHER4);
         expected_bits.push_back(bits);

         // zero width acts as one, oversize saturates
         width_eff = int'(line_width);
         if (width_eff < 1) width_eff = 1;
         if (width_eff > MAX_WIDTH_DEF) width_eff = MAX_WIDTH_DEF;
         if (int'(column_count) + 1 >= width_eff) begin
            column_count = '0;
            col_phase    = '0;
            row_phase    = 4'((int'(row_phase) + 1) % PHASE_MOD);
         end else begin
            column_count = column_count + 12'd1;
            col_phase    = 4'((int'(col_phase) + 1) % PHASE_MOD);
         end
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("%0t ns: mismatch on %s, got %0d want %0d (result %0d)",
                  $time, what, got, want, results_checked);
         mismatches++;
      endtask

      task check_bits(rsp_type got);
         rsp_type want;
         results_checked++;
         if (expected_bits.size() == 0) begin
            report_mismatch("unexpected word", int'(got), -1);
            return;
         end
         want = expected_bits.pop_front();
         if (got.bit_2x2 !== want.bit_2x2) report_mismatch("bit_2x2", got.bit_2x2, want.bit_2x2);
         if (got.bit_3x3 !== want.bit_3x3) report_mismatch("bit_3x3", got.bit_3x3, want.bit_3x3);
         if (got.bit_4x4 !== want.bit_4x4) report_mismatch("bit_4x4", got.bit_4x4, want.bit_4x4);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_index;
   logic [CSR_W-1:0] csr_data;

   dither_scoreboard pix_sb;
   bit               hold_wanted;
   int               held_cycles;
   int               settings_used;

   ordered_dither_three_sizes_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 2 ns clock
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #600000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Both handshakes are sampled here at the rising edge. The output word is
   // checked before the input word is noted; with the input and result registers
   // in between, the word leaving never belongs to the word entering on the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) pix_sb.check_bits(rsp_data);
         if (req_valid && !req_stall) pix_sb.note_pixel(req_data);
      end
   end

   // Output side: stall segments of random flavor and length. Once the random
   // part starts, one long hold is counted here while the sender keeps going,
   // so the pipeline fills and the input gets stalled.
   initial begin : rsp_side
      int seg_kind;
      int seg_len;
      int hold_len;
      rsp_stall   = 1'b0;
      held_cycles = 0;
      wait (!reset);
      forever begin
         if (hold_wanted && held_cycles == 0) begin
            hold_len = $urandom_range(150, 300);
            repeat (hold_len) begin
               @(negedge clock);
               rsp_stall = 1'b1;
               held_cycles++;
            end
         end
         seg_kind = $urandom_range(0, 3);
         seg_len  = $urandom_range(10, 80);
         repeat (seg_len) begin
            @(negedge clock);
            case (seg_kind)
               0: rsp_stall = 1'b0;                          // free flow
               1: rsp_stall = ($urandom_range(0, 3) == 0);   // light
               2: rsp_stall = ($urandom_range(0, 3) != 0);   // heavy
               default: rsp_stall = ($urandom_range(0, 2) == 0) ? ~rsp_stall : rsp_stall;
            endcase
         end
      end
   end

   // Offer one pixel word and hold it until taken
   task automatic send_pixel(logic [7:0] gray, bit fs);
      @(negedge clock);
      req_valid            = 1'b1;
      req_data.gray        = gray;
      req_data.frame_start = fs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Sender gap; payload is junk while valid is low
   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         req_valid = 1'b0;
         req_data  = req_type'($urandom);
      end
   endtask

   // Quiesce: no word offered, nothing pending, pipeline empty
   task automatic settle_block();
      @(negedge clock);
      req_valid = 1'b0;
      while (pix_sb.expected_bits.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      pix_sb.set_register(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
      csr_data  = CSR_W'($urandom);
   endtask

   // One register setting, then a stream of frames in bursts
   task automatic run_setting(logic [CSR_W-1:0] mv, logic [CSR_W-1:0] lw, int count);
      int         sent;
      int         burst;
      int         nsq;
      int         stepv;
      int         g;
      bit         fs;
      settle_block();
      write_reg(CSR_GRAY_PEAK, mv);
      write_reg(CSR_LINE_WIDTH, lw);
      settings_used++;
      sent = 0;
      while (sent < count) begin
         burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
         for (int i = 0; i < burst && sent < count; i++) begin
            // mostly clean frames; now and then a frame restarts mid-row
            fs = (sent == 0) || ($urandom_range(0, 63) == 0);
            if ($urandom_range(0, 2) == 0) begin
               // land on or just past a level edge of one of the sizes
               nsq   = ($urandom_range(0, 2) == 0) ? 4 : (($urandom_range(0, 1) == 0) ? 9 : 16);
               stepv = int'(mv[7:0]) / nsq;
               g     = $urandom_range(1, nsq - 1) * stepv + $urandom_range(0, 1);
               if (g > 255) g = 255;
            end else begin
               g = $urandom_range(0, 255);
            end
            send_pixel(8'(g), fs);
            sent++;
         end
         if ($urandom_range(0, 4) != 0) idle_cycles($urandom_range(1, 6));
      end
   endtask

   initial begin : stimulus
      logic [CSR_W-1:0] mv_list [12];
      logic [CSR_W-1:0] lw_list [12];
      pix_sb        = new();
      hold_wanted   = 1'b0;
      settings_used = 1;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_valid     = 1'b0;
      csr_index     = CSR_GRAY_PEAK;
      csr_data      = '0;
      mv_list = '{13'd255, 13'd1, 13'd0, 13'd2, 13'd3, 13'd4,
                  13'd9, 13'd16, 13'd254, 13'd100, 13'h1F37, 13'd8};
      lw_list = '{13'd1, 13'd0, 13'd2, 13'd3, 13'd4, 13'd5,
                  13'd12, 13'd7, 13'd4096, 13'd13, 13'd8191, 13'd640};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset values: 255 and 640; grays on the step edges of all three sizes
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd63, 1'b0);
      send_pixel(8'd64, 1'b0);
      send_pixel(8'd15, 1'b0);
      send_pixel(8'd16, 1'b0);
      send_pixel(8'd28, 1'b0);
      send_pixel(8'd29, 1'b0);
      send_pixel(8'd240, 1'b0);
      send_pixel(8'd241, 1'b0);

      // peak gray 0 gives zero steps; zero width ends a row every pixel
      settle_block();
      write_reg(CSR_GRAY_PEAK, 13'd0);
      write_reg(CSR_LINE_WIDTH, 13'd0);
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd1, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd128, 1'b0);

      // upper data bits of the peak gray dropped (4 left): small step sizes
      settle_block();
      write_reg(CSR_GRAY_PEAK, 13'h1F04);
      write_reg(CSR_LINE_WIDTH, 13'd5);
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd1, 1'b0);
      send_pixel(8'd2, 1'b0);
      send_pixel(8'd3, 1'b0);

      // width shrinks below the column reached: row ends after next pixel
      settle_block();
      write_reg(CSR_LINE_WIDTH, 13'd3);
      send_pixel(8'd5, 1'b0);
      send_pixel(8'd200, 1'b0);
      send_pixel(8'd90, 1'b1);   // frame restart mid-row

      // width past the maximum saturates
      settle_block();
      write_reg(CSR_GRAY_PEAK, 13'd1);
      write_reg(CSR_LINE_WIDTH, 13'd8191);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd1, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd2, 1'b0);

      // Random part, with the long output hold requested at its start
      hold_wanted = 1'b1;
      for (int p = 0; p < 12; p++)
         run_setting(mv_list[p], lw_list[p], 162);

      settle_block();
      repeat (8) @(posedge clock);

      $display("Covered %0d pixels under %0d register settings; %0d words checked.",
               pix_sb.pixels_seen, settings_used, pix_sb.results_checked);
      $display("Output held off for %0d cycles in one stretch; %0d mismatches.",
               held_cycles, pix_sb.mismatches);
      if (pix_sb.mismatches == 0 && pix_sb.expected_bits.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
